// ===== hdl/bdmn_pkg.sv =====
// types and constants for the button debouncer and menu navigator
// no dependencies; imported by button_debounce_menu_navigator
package bdmn_pkg;

  localparam int NUM_BUTTONS = 3;

  // button lanes, lowest first
  localparam logic [1:0] BTN_UP     = 2'd0;
  localparam logic [1:0] BTN_DOWN   = 2'd1;
  localparam logic [1:0] BTN_SELECT = 2'd2;

  localparam int         MODE_COUNT = 7;
  localparam logic [2:0] MODE_LAST  = 3'(MODE_COUNT - 1);

  // modes that own a submenu counter
  localparam logic [2:0] MODE_OPTION    = 3'd0;
  localparam logic [2:0] MODE_TAB_THREE = 3'd3;
  localparam logic [2:0] MODE_TAB_FOUR  = 3'd4;

  localparam logic [1:0] TAB_LAST = 2'd2;

  localparam logic [7:0]             THRESHOLD_RESET = 8'd10;
  // up and down start with stable level high, select starts low
  localparam logic [NUM_BUTTONS-1:0] STABLE_RESET    = 3'b011;

  typedef struct packed {
    logic [1:0] tab_four;
    logic [1:0] tab_three;
    logic [1:0] option;
    logic       in_submenu;
    logic [2:0] mode;
  } nav_t;

  localparam nav_t NAV_RESET = '0;

endpackage

// ===== hdl/button_debounce_menu_navigator.sv =====
// button debouncer and two-level menu navigator, single module
// depends on bdmn_pkg
// path: an accepted input transaction passes the input register, then the result register,
//   to its result; throughput: one transaction per cycle while the output is taken
// an input register and a result register let one more item in while a result waits
// reset (rst, synchronous): counters cleared, stable levels up 1 / down 1 / select 0,
//   menu at home mode 0, threshold 10, both stages empty
module button_debounce_menu_navigator
  import bdmn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pin_up, pin_down, pin_select, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // mode[2:0], in_submenu, option[1:0], tab_three[1:0],
                                      // tab_four[1:0], fired[2:0], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0]             threshold;
  logic [7:0]             count      [NUM_BUTTONS];
  logic [7:0]             count_next [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] stable;
  logic [NUM_BUTTONS-1:0] stable_next;
  logic [NUM_BUTTONS-1:0] fired_next;
  nav_t                   nav;
  nav_t                   nav_next;

  logic                   in_valid;
  logic [NUM_BUTTONS-1:0] in_pins;
  logic                   out_valid;
  nav_t                   out_nav;
  logic [NUM_BUTTONS-1:0] out_fired;

  logic advance;
  logic step;

  assign advance       = !out_valid || m_axis_tready;
  assign step          = advance && in_valid;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  function automatic nav_t apply_event(input nav_t s, input logic [1:0] btn);
    nav_t r;
    logic fwd;
    r   = s;
    fwd = (btn == BTN_UP);
    if (!s.in_submenu) begin
      if (btn == BTN_UP) begin
        r.mode = (s.mode == MODE_LAST) ? 3'd0 : s.mode + 3'd1;
      end else if (btn == BTN_DOWN) begin
        r.mode = (s.mode == 3'd0) ? MODE_LAST : s.mode - 3'd1;
      end else begin
        r.in_submenu = 1'b1;
        r.option     = 2'd0;
      end
    end else if (btn == BTN_SELECT) begin
      r.in_submenu = 1'b0;
    end else if (s.mode == MODE_OPTION) begin
      r.option = fwd ? s.option + 2'd1 : s.option - 2'd1;
    end else if (s.mode == MODE_TAB_THREE) begin
      if (fwd) r.tab_three = (s.tab_three == TAB_LAST) ? 2'd0 : s.tab_three + 2'd1;
      else     r.tab_three = (s.tab_three == 2'd0) ? TAB_LAST : s.tab_three - 2'd1;
    end else if (s.mode == MODE_TAB_FOUR) begin
      if (fwd) r.tab_four = (s.tab_four == TAB_LAST) ? 2'd0 : s.tab_four + 2'd1;
      else     r.tab_four = (s.tab_four == 2'd0) ? TAB_LAST : s.tab_four - 2'd1;
    end
    return r;
  endfunction

  // per-button settle counters, independent lanes
  always_comb begin
    logic [7:0] inc;
    logic       level;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      level          = ~in_pins[i];
      inc            = count[i] + 8'd1;
      stable_next[i] = stable[i];
      fired_next[i]  = 1'b0;
      count_next[i]  = 8'd0;
      if (level != stable[i]) begin
        if (inc >= threshold) begin
          stable_next[i] = level;
          fired_next[i]  = ~level;
        end else begin
          count_next[i] = inc;
        end
      end
    end
  end

  // events in order up, down, select
  always_comb begin
    nav_t s;
    s = nav;
    if (fired_next[BTN_UP])     s = apply_event(s, BTN_UP);
    if (fired_next[BTN_DOWN])   s = apply_event(s, BTN_DOWN);
    if (fired_next[BTN_SELECT]) s = apply_event(s, BTN_SELECT);
    nav_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      stable    <= STABLE_RESET;
      nav       <= NAV_RESET;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        count[i] <= 8'd0;
      end
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (step) begin
        stable <= stable_next;
        nav    <= nav_next;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          count[i] <= count_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_pins <= s_axis_tdata[NUM_BUTTONS-1:0];
    end
    if (step) begin
      out_nav   <= nav_next;
      out_fired <= fired_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_fired, out_nav.tab_four, out_nav.tab_three,
                          out_nav.option, out_nav.in_submenu, out_nav.mode};

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    nav.mode <= MODE_LAST)
    else $error("mode outside the mode count");

  a_tab_range: assert property (@(posedge clk) disable iff (rst)
    nav.tab_three != 2'd3 && nav.tab_four != 2'd3)
    else $error("tab counter outside its range");

  // an event is only reported for a button that just settled released
  a_fired_release: assert property (@(posedge clk) disable iff (rst)
    step |=> (out_fired & stable) == 3'b000)
    else $error("event fired for a button whose stable level is high");

endmodule
